/* hdl/registry_bump_allocator_top_defines.svh */
// ----------------------------------------------------------------------------
// Registry bump allocator assertion macros
// Shared property macros for the checker of the allocator's ports.
// ----------------------------------------------------------------------------
`ifndef REGISTRY_BUMP_ALLOCATOR_TOP_DEFINES_SVH
`define REGISTRY_BUMP_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define RBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define RBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

/* hdl/rba_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Registry bump allocator package
// Shared constants, status codes and the control word passed between cells.
// ----------------------------------------------------------------------------
package rba_pkg;

  localparam int unsigned RegistryEntriesDef = 16;
  localparam int unsigned AddrBitsDef        = 24;
  localparam int unsigned FieldW             = 24;
  localparam int unsigned StatusW            = 3;

  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_NOT_INIT = 3'd1;
  localparam logic [StatusW-1:0] ST_ZERO     = 3'd2;
  localparam logic [StatusW-1:0] ST_EXCEEDS  = 3'd3;
  localparam logic [StatusW-1:0] ST_HANDLE   = 3'd4;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd5;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Control part of the request that walks along the cell row.
  typedef struct packed {
    logic               vld;     // a request occupies this slot
    logic               act;     // request passed its checks and may touch entries
    logic               mode;
    logic [StatusW-1:0] status;  // outcome of the up-front checks
    logic               hit;     // some earlier cell already served the request
    logic               reused;  // the serving cell was a freed entry
  } rba_ctl_t;

endpackage

/* hdl/rba_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Registry bump allocator cell
// Holds one registry entry and serves the request passing through it.
// ----------------------------------------------------------------------------
module rba_cell import rba_pkg::*; #(
  parameter int unsigned AW = AddrBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  rba_ctl_t      ctl_i,
  input  logic [AW-1:0] amount_i,
  input  logic [AW-1:0] base_i,
  input  logic [AW-1:0] hoff_i,
  input  logic [AW-1:0] off_i,
  output rba_ctl_t      ctl_o,
  output logic [AW-1:0] amount_o,
  output logic [AW-1:0] base_o,
  output logic [AW-1:0] hoff_o,
  output logic [AW-1:0] off_o
);

  logic          valid_q, valid_d;
  logic          used_q, used_d;
  logic [AW-1:0] cap_q, cap_d;
  logic [AW-1:0] ofs_q, ofs_d;
  rba_ctl_t      ctl_q, ctl_d;
  logic [AW-1:0] amount_q, base_q, hoff_q, off_q, off_d;
  logic          fit;

  assign fit = valid_q && !used_q && (cap_q >= amount_i) && (amount_i >= (cap_q >> 1));

  always_comb begin
    valid_d = valid_q;
    used_d  = used_q;
    cap_d   = cap_q;
    ofs_d   = ofs_q;
    ctl_d   = ctl_i;
    off_d   = off_i;
    if (ctl_i.vld && ctl_i.act && !ctl_i.hit) begin
      if (ctl_i.mode == MODE_FREE) begin
        if (valid_q && (ofs_q == hoff_i)) begin
          used_d    = 1'b0;
          ctl_d.hit = 1'b1;
        end
      end else if (fit) begin
        used_d       = 1'b1;
        ctl_d.hit    = 1'b1;
        ctl_d.reused = 1'b1;
        off_d        = ofs_q;
      end else if (!valid_q) begin
        // Entries fill in order, so the first empty cell is the append slot.
        valid_d   = 1'b1;
        used_d    = 1'b1;
        cap_d     = amount_i;
        ofs_d     = base_i;
        ctl_d.hit = 1'b1;
        off_d     = base_i;
      end
    end
    if (clear_i) begin
      valid_d = 1'b0;
      used_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      used_q  <= 1'b0;
      ctl_q   <= '0;
    end else begin
      valid_q <= valid_d;
      used_q  <= used_d;
      ctl_q   <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q    <= cap_d;
    ofs_q    <= ofs_d;
    amount_q <= amount_i;
    base_q   <= base_i;
    hoff_q   <= hoff_i;
    off_q    <= off_d;
  end

  assign ctl_o    = ctl_q;
  assign amount_o = amount_q;
  assign base_o   = base_q;
  assign hoff_o   = hoff_q;
  assign off_o    = off_q;

endmodule

/* hdl/registry_bump_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Registry bump allocator
// Byte pool allocator with a registry of blocks that freed entries reuse.
// ----------------------------------------------------------------------------
// Usage:
//   Configure the pool size through the cfg beat channel; every write clears
//   the registry and the consumed byte count. cfg_ready_o is low while busy
//   and while start is high, so a write never meets a request in flight.
//   A request is taken at a rising edge with start high and busy low. mode_i
//   selects allocate or free. The request then walks the row of registry
//   cells, one cell per cycle, each cell checking and updating its own entry.
//   The result appears on status_o, offset_o, reused_o and found_o for one
//   cycle with done_o high, once the request has left the last cell. busy
//   drops at the edge that ends that cycle, so a new request is taken only
//   after the last one has passed the whole cell row.
//   The receiver cannot stall; it must take each result in its done_o cycle.
//   Reset clears the pool size to zero (allocate reports not initialized),
//   empties the registry and leaves the block idle.
// ----------------------------------------------------------------------------
module registry_bump_allocator_top import rba_pkg::*; #(
  parameter int unsigned REGISTRY_ENTRIES = RegistryEntriesDef,
  parameter int unsigned ADDR_BITS        = AddrBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic [FieldW-1:0]  amount_i,
  input  logic               handle_set_i,
  input  logic [FieldW-1:0]  handle_offset_i,
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic [FieldW-1:0]  offset_o,
  output logic               reused_o,
  output logic               found_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [FieldW-1:0]  cfg_data_i
);

  localparam int unsigned N  = REGISTRY_ENTRIES;
  localparam int unsigned AW = ADDR_BITS;

  logic          busy_q, busy_d;
  logic [AW-1:0] pool_q, pool_d;
  logic [AW-1:0] consumed_q, consumed_d;
  logic          cfg_wr, accept;
  logic [AW-1:0] amt, hoff;
  logic [StatusW-1:0] pre_status;

  rba_ctl_t      ctl_w    [0:N];
  logic [AW-1:0] amount_w [0:N];
  logic [AW-1:0] base_w   [0:N];
  logic [AW-1:0] hoff_w   [0:N];
  logic [AW-1:0] off_w    [0:N];

  rba_ctl_t      last;
  logic          alloc_ok, appended;

  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = !busy_q && !start;
  assign accept      = start && !busy_q;
  assign busy        = busy_q;

  assign amt  = AW'(amount_i);
  assign hoff = AW'(handle_offset_i);

  always_comb begin
    priority if (pool_q == '0) begin
      pre_status = ST_NOT_INIT;
    end else if (amt == '0) begin
      pre_status = ST_ZERO;
    end else if ((consumed_q > pool_q) || (amt > (pool_q - consumed_q))) begin
      pre_status = ST_EXCEEDS;
    end else if (handle_set_i) begin
      pre_status = ST_HANDLE;
    end else begin
      pre_status = ST_OK;
    end
  end

  always_comb begin
    ctl_w[0]        = '0;
    ctl_w[0].vld    = accept;
    ctl_w[0].mode   = mode_i;
    ctl_w[0].status = (mode_i == MODE_FREE) ? ST_OK : pre_status;
    ctl_w[0].act    = (mode_i == MODE_FREE) || (pre_status == ST_OK);
  end
  assign amount_w[0] = amt;
  assign base_w[0]   = consumed_q;
  assign hoff_w[0]   = hoff;
  assign off_w[0]    = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rba_cell #(
      .AW(AW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (cfg_wr),
      .ctl_i   (ctl_w[i]),
      .amount_i(amount_w[i]),
      .base_i  (base_w[i]),
      .hoff_i  (hoff_w[i]),
      .off_i   (off_w[i]),
      .ctl_o   (ctl_w[i+1]),
      .amount_o(amount_w[i+1]),
      .base_o  (base_w[i+1]),
      .hoff_o  (hoff_w[i+1]),
      .off_o   (off_w[i+1])
    );
  end

  assign last     = ctl_w[N];
  assign done_o   = last.vld;
  assign alloc_ok = (last.mode == MODE_ALLOC) && (last.status == ST_OK) && last.hit;
  assign appended = last.vld && alloc_ok && !last.reused;

  always_comb begin
    if (last.mode == MODE_FREE) begin
      status_o = ST_OK;
    end else if (last.status != ST_OK) begin
      status_o = last.status;
    end else if (!last.hit) begin
      status_o = ST_FULL;
    end else begin
      status_o = ST_OK;
    end
  end

  assign offset_o = alloc_ok ? FieldW'(off_w[N]) : '0;
  assign reused_o = alloc_ok && last.reused;
  assign found_o  = (last.mode == MODE_FREE) && last.hit;

  always_comb begin
    busy_d     = busy_q;
    pool_d     = pool_q;
    consumed_d = consumed_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (done_o) begin
      busy_d = 1'b0;
    end
    if (appended) begin
      consumed_d = consumed_q + amount_w[N];
    end
    if (cfg_wr) begin
      pool_d     = AW'(cfg_data_i);
      consumed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pool_q     <= '0;
      consumed_q <= '0;
    end else begin
      busy_q     <= busy_d;
      pool_q     <= pool_d;
      consumed_q <= consumed_d;
    end
  end

endmodule

/* hdl/rba_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Registry bump allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "registry_bump_allocator_top_defines.svh"

module rba_checker import rba_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               done_o,
  input logic [StatusW-1:0] status_o,
  input logic [FieldW-1:0]  offset_o,
  input logic               reused_o,
  input logic               found_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o
);

  // A result only shows up while its request still holds the block.
  `RBA_ASSERT_NOW(a_done_busy, clk_i, rst_ni, done_o, busy)

  // A taken request keeps the block busy in the following cycle.
  `RBA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)

  // Failed requests report no block.
  `RBA_ASSERT_NOW(a_fail_clean, clk_i, rst_ni, done_o && (status_o != ST_OK),
                  (offset_o == '0) && !reused_o && !found_o)

  // A free hit and a reuse never come together.
  `RBA_ASSERT_NOW(a_found_excl, clk_i, rst_ni, done_o && found_o,
                  (status_o == ST_OK) && !reused_o)

  // The configuration port is closed while a request is in flight.
  `RBA_ASSERT_NOW(a_cfg_idle, clk_i, rst_ni, busy || start, !cfg_ready_o)

endmodule

bind registry_bump_allocator_top rba_checker u_rba_checker (.*);

/* tb/tb_registry_bump_allocator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Registry bump allocator testbench
// Sends allocate and free requests with random gaps, predicts each result
// from a local model of the pool and registry, and checks every done beat.
// ----------------------------------------------------------------------------
module tb_registry_bump_allocator_top;
  import rba_pkg::*;

  localparam int unsigned SLOTS       = RegistryEntriesDef;
  localparam int unsigned DRAIN       = RegistryEntriesDef + 4;
  localparam logic [FieldW-1:0] FIELD_MAX = '1;
  localparam int unsigned MAX_PRINTS  = 100;

  typedef struct packed {
    logic              mode;
    logic [FieldW-1:0] amount;
    logic              handle_set;
    logic [FieldW-1:0] handle_offset;
  } request_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [FieldW-1:0]  offset;
    logic               reused;
    logic               found;
  } outcome_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              mode_i = MODE_ALLOC;
  logic [FieldW-1:0] amount_i = '0;
  logic              handle_set_i = 1'b0;
  logic [FieldW-1:0] handle_offset_i = '0;
  logic              done_o;
  logic [StatusW-1:0] status_o;
  logic [FieldW-1:0] offset_o;
  logic              reused_o;
  logic              found_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [FieldW-1:0] cfg_data_i = '0;

  // Local copy of the allocator state.
  logic [FieldW-1:0] pool_bytes;
  logic              slot_used [SLOTS];
  logic [FieldW-1:0] slot_capacity [SLOTS];
  logic [FieldW-1:0] slot_offset [SLOTS];
  int unsigned       slot_count;
  logic [FieldW-1:0] consumed_bytes;

  outcome_t    pending_outcomes [$];
  outcome_t    oldest_outcome;
  int unsigned error_count = 0;
  int unsigned done_count = 0;

  registry_bump_allocator_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .amount_i       (amount_i),
    .handle_set_i   (handle_set_i),
    .handle_offset_i(handle_offset_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .offset_o       (offset_o),
    .reused_o       (reused_o),
    .found_o        (found_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void clear_registry(input logic [FieldW-1:0] size);
    pool_bytes = size;
    slot_count = 0;
    consumed_bytes = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
    end
  endfunction

  // Applies one request to the local state and returns the result it yields.
  function automatic outcome_t apply_request(input request_t req);
    outcome_t res;
    logic     hit;
    res = '0;
    res.status = ST_OK;
    hit = 1'b0;
    if (req.mode == MODE_FREE) begin
      for (int i = 0; i < slot_count; i++) begin
        if (!hit && slot_offset[i] == req.handle_offset) begin
          slot_used[i] = 1'b0;
          res.found = 1'b1;
          hit = 1'b1;
        end
      end
    end else if (pool_bytes == '0) begin
      res.status = ST_NOT_INIT;
    end else if (req.amount == '0) begin
      res.status = ST_ZERO;
    end else if (consumed_bytes > pool_bytes || req.amount > pool_bytes - consumed_bytes) begin
      res.status = ST_EXCEEDS;
    end else if (req.handle_set) begin
      res.status = ST_HANDLE;
    end else begin
      // A freed block is taken when it holds the request and is at most about twice its size.
      for (int i = 0; i < slot_count; i++) begin
        if (!hit && !slot_used[i] && slot_capacity[i] >= req.amount &&
            req.amount >= (slot_capacity[i] >> 1)) begin
          slot_used[i] = 1'b1;
          res.offset = slot_offset[i];
          res.reused = 1'b1;
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (slot_count >= SLOTS) begin
          res.status = ST_FULL;
        end else begin
          slot_used[slot_count] = 1'b1;
          slot_capacity[slot_count] = req.amount;
          slot_offset[slot_count] = consumed_bytes;
          res.offset = consumed_bytes;
          slot_count++;
          consumed_bytes = consumed_bytes + req.amount;
        end
      end
    end
    return res;
  endfunction

  function automatic request_t make_request(input logic mode, input logic [FieldW-1:0] amount,
                                            input logic hs, input logic [FieldW-1:0] ho);
    request_t req;
    req.mode = mode;
    req.amount = amount;
    req.handle_set = hs;
    req.handle_offset = ho;
    return req;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // Printing stops after a while so a broken build does not flood the log.
    if (error_count < MAX_PRINTS) begin
      $display("ERROR: result %0d: %s is 0x%0h, expected 0x%0h", done_count, what, got, want);
    end
    error_count++;
  endtask

  // Start is left high after a beat when the next one follows with no gap.
  task automatic send_request(input request_t req, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    mode_i <= req.mode;
    amount_i <= req.amount;
    handle_set_i <= req.handle_set;
    handle_offset_i <= req.handle_offset;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_outcomes.push_back(apply_request(req));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_pool_size(input logic [FieldW-1:0] size);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= size;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    clear_registry(size);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned draw_gap(input bit idle_on);
    return idle_on ? $urandom_range(0, 11) : 0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      done_count++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status_o), 32'd0);
      end else begin
        oldest_outcome = pending_outcomes.pop_front();
        if (status_o !== oldest_outcome.status)
          report_mismatch("status", 32'(status_o), 32'(oldest_outcome.status));
        if (offset_o !== oldest_outcome.offset)
          report_mismatch("offset", 32'(offset_o), 32'(oldest_outcome.offset));
        if (reused_o !== oldest_outcome.reused)
          report_mismatch("reused", 32'(reused_o), 32'(oldest_outcome.reused));
        if (found_o !== oldest_outcome.found)
          report_mismatch("found", 32'(found_o), 32'(oldest_outcome.found));
      end
    end
  end

  task automatic test_unconfigured();
    send_request(make_request(MODE_ALLOC, 24'd5, 1'b1, FIELD_MAX), draw_gap(1'b1));
    send_request(make_request(MODE_FREE, '0, 1'b0, '0), draw_gap(1'b1));
  endtask

  task automatic test_check_order();
    write_pool_size(FIELD_MAX);
    send_request(make_request(MODE_ALLOC, '0, 1'b1, '0), draw_gap(1'b1));
    send_request(make_request(MODE_ALLOC, FIELD_MAX, 1'b1, '0), draw_gap(1'b1));
    send_request(make_request(MODE_ALLOC, FIELD_MAX, 1'b0, FIELD_MAX), draw_gap(1'b1));
    send_request(make_request(MODE_ALLOC, 24'd1, 1'b1, '0), draw_gap(1'b1));
    send_request(make_request(MODE_FREE, FIELD_MAX, 1'b1, FIELD_MAX), draw_gap(1'b1));
    send_request(make_request(MODE_FREE, FIELD_MAX, 1'b1, '0), draw_gap(1'b1));
    // The freed block cannot be reused: the space check comes first.
    send_request(make_request(MODE_ALLOC, 24'd1, 1'b0, '0), draw_gap(1'b1));
  endtask

  task automatic test_full_and_reuse();
    write_pool_size(24'd1000);
    for (int i = 0; i <= SLOTS; i++) begin
      send_request(make_request(MODE_ALLOC, 24'd10, 1'b0, '0), draw_gap(1'(i % 2)));
    end
    send_request(make_request(MODE_FREE, '0, 1'b0, 24'd20), draw_gap(1'b1));
    // Just below half the freed capacity, then exactly half of it.
    send_request(make_request(MODE_ALLOC, 24'd4, 1'b0, '0), draw_gap(1'b1));
    send_request(make_request(MODE_ALLOC, 24'd5, 1'b0, '0), draw_gap(1'b1));
  endtask

  function automatic request_t random_request(input int unsigned max_amount);
    request_t    req;
    int unsigned pick;
    int unsigned freed [$];
    logic [FieldW-1:0] cap;
    logic [FieldW-1:0] low;
    req.mode = MODE_ALLOC;
    req.amount = FieldW'($urandom_range(1, max_amount));
    req.handle_set = 1'b0;
    req.handle_offset = FieldW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      for (int i = 0; i < slot_count; i++) begin
        if (!slot_used[i]) freed.push_back(i);
      end
      if (freed.size() != 0 && $urandom_range(0, 9) < 5) begin
        cap = slot_capacity[freed[$urandom_range(0, freed.size() - 1)]];
        low = (cap >> 1) == '0 ? 24'd1 : cap >> 1;
        req.amount = FieldW'($urandom_range(low, cap));
      end
    end else if (pick < 85) begin
      req.mode = MODE_FREE;
      req.amount = FieldW'($urandom);
      req.handle_set = 1'($urandom_range(0, 1));
      if (pick < 78 && slot_count != 0)
        req.handle_offset = slot_offset[$urandom_range(0, slot_count - 1)];
    end else if (pick < 90) begin
      req.amount = '0;
      req.handle_set = 1'($urandom_range(0, 1));
    end else if (pick < 95) begin
      req.handle_set = 1'b1;
    end else begin
      req.amount = FieldW'($urandom);
      req.handle_set = 1'($urandom_range(0, 1));
    end
    return req;
  endfunction

  task automatic run_traffic(input logic [FieldW-1:0] size, input int unsigned count,
                             input int unsigned max_amount, input bit idle_on);
    write_pool_size(size);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 49) == 0) wait_for_results();
      send_request(random_request(max_amount), draw_gap(idle_on));
    end
  endtask

  task automatic test_random_traffic();
    logic [FieldW-1:0] size;
    run_traffic(FIELD_MAX, 100, 32'h001F_FFFF, 1'b1);
    run_traffic(24'd1, 60, 1, 1'b0);
    run_traffic('0, 40, 64, 1'b1);
    for (int k = 0; k < 5; k++) begin
      size = FieldW'($urandom_range(16, 4096));
      run_traffic(size, 100, size / $urandom_range(4, 20) + 1, k != 2);
    end
    size = FieldW'($urandom) | 24'h100;
    run_traffic(size, 100, size / 10, 1'b1);
  endtask

  initial begin
    clear_registry('0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unconfigured();
    test_check_order();
    test_full_and_reuse();
    test_random_traffic();
    wait_for_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rba_pkg.sv
hdl/rba_cell.sv
hdl/registry_bump_allocator_top.sv
hdl/rba_checker.sv
tb/tb_registry_bump_allocator_top.sv
